### rtl/core/lgge_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the cell rule of the grid generation engine.
package lgge_pkg;

    localparam int GRID_COLS_DEF = 32;
    localparam int GRID_ROWS_DEF = 24;
    localparam int REQ_W         = 2;
    localparam int COORD_W       = 5;
    localparam int NBR_W         = 4;

    typedef logic [REQ_W-1:0]   t_req;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [NBR_W-1:0]   t_nbr_count;

    localparam t_req REQ_TICK   = t_req'(0);
    localparam t_req REQ_PAUSE  = t_req'(1);
    localparam t_req REQ_TOGGLE = t_req'(2);
    localparam t_req REQ_READ   = t_req'(3);

    localparam t_nbr_count LIVE_KEEP  = t_nbr_count'(2);
    localparam t_nbr_count LIVE_BIRTH = t_nbr_count'(3);

    // A live cell stays with two or three live neighbors; a dead one is born with three.
    function automatic logic cell_rule(input logic alive, input t_nbr_count count);
        return (count == LIVE_BIRTH) || (alive && (count == LIVE_KEEP));
    endfunction

endpackage

### rtl/core/lgge_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the grid generation engine.
interface lgge_req_if;
    logic               valid;
    logic               ready;
    lgge_pkg::t_req     req_type;
    lgge_pkg::t_coord   cell_col;
    lgge_pkg::t_coord   cell_row;

    modport source (output valid, output req_type, output cell_col, output cell_row,
                    input ready);
    modport sink (input valid, input req_type, input cell_col, input cell_row,
                  output ready);
endinterface

interface lgge_rsp_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic paused;
    logic ignored;

    modport source (output valid, output cell_alive, output paused, output ignored,
                    input ready);
    modport sink (input valid, input cell_alive, input paused, input ignored,
                  output ready);
endinterface

### rtl/core/lgge_row_unit.sv
`timescale 1ns / 1ps
// Row update unit that computes the next generation of one grid row.
module lgge_row_unit #(
    parameter int GRID_COLS = lgge_pkg::GRID_COLS_DEF
) (
    input  logic [GRID_COLS-1:0] i_prev,
    input  logic [GRID_COLS-1:0] i_cur,
    input  logic [GRID_COLS-1:0] i_next,
    output logic [GRID_COLS-1:0] o_row
);

    logic [GRID_COLS+1:0] prev_pad;
    logic [GRID_COLS+1:0] cur_pad;
    logic [GRID_COLS+1:0] next_pad;

    assign prev_pad = {1'b0, i_prev, 1'b0};
    assign cur_pad  = {1'b0, i_cur, 1'b0};
    assign next_pad = {1'b0, i_next, 1'b0};

    always_comb begin
        lgge_pkg::t_nbr_count count;
        count = '0;
        o_row = '0;
        for (int c = 0; c < GRID_COLS; c++) begin
            count = lgge_pkg::t_nbr_count'(prev_pad[c]) + lgge_pkg::t_nbr_count'(prev_pad[c+1])
                  + lgge_pkg::t_nbr_count'(prev_pad[c+2]) + lgge_pkg::t_nbr_count'(cur_pad[c])
                  + lgge_pkg::t_nbr_count'(cur_pad[c+2]) + lgge_pkg::t_nbr_count'(next_pad[c])
                  + lgge_pkg::t_nbr_count'(next_pad[c+1])
                  + lgge_pkg::t_nbr_count'(next_pad[c+2]);
            o_row[c] = lgge_pkg::cell_rule(i_cur[c], count);
        end
    end

endmodule

### rtl/core/life_grid_generation_engine.sv
`timescale 1ns / 1ps
// Top level of the bounded grid generation engine with its row memory and sequencer.
// The grid is kept one row per memory word, and a single row update unit walks the rows
// in order. A generation tick while running reads each row through the single read port,
// drains the three-row window, reads the addressed cell and then loads the response
// register. Pause toggles, paused ticks, cell toggles and cell reads go through the
// look-up state, which reads the addressed row, and the cell state, which loads the
// response register once it is free. The sequencer then returns to idle, where the next
// request is taken. A new request is taken only when the previous one has been handed to
// the response register, which holds one word while the consumer stalls. Reset clears the
// grid at once through per-row valid bits, so no clearing pass is needed.
module life_grid_generation_engine #(
    parameter int GRID_COLS = lgge_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = lgge_pkg::GRID_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgge_req_if.sink    i_req,
    lgge_rsp_if.source  o_rsp
);

    localparam int COL_AW = $clog2(GRID_COLS);
    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int CNT_W  = $clog2(GRID_ROWS + 2);
    localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(GRID_ROWS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_ROWS + 1);
    localparam logic [CNT_W-1:0] CNT_LAG  = CNT_W'(2);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_CELL = 4'b0100,
        S_GEN  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_pause, n_pause;
    lgge_pkg::t_req          r_type;
    lgge_pkg::t_coord        r_col;
    lgge_pkg::t_coord        r_row;
    logic [GRID_ROWS-1:0]    r_row_valid;
    logic [GRID_COLS-1:0]    r_mem [GRID_ROWS];
    logic [GRID_COLS-1:0]    r_rdata;
    logic                    r_rvalid;
    logic [GRID_COLS-1:0]    r_prev;
    logic [GRID_COLS-1:0]    r_cur;
    logic                    r_out_valid, n_out_valid;
    logic                    r_alive;
    logic                    r_paused;
    logic                    r_ignored;

    logic                    accept;
    logic                    slot_free;
    logic                    in_range;
    logic [COL_AW-1:0]       col_idx;
    logic [ROW_AW-1:0]       row_idx;
    logic                    rd_en;
    logic [ROW_AW-1:0]       rd_addr;
    logic                    wr_en;
    logic [ROW_AW-1:0]       wr_addr;
    logic [GRID_COLS-1:0]    wr_data;
    logic [GRID_COLS-1:0]    row_data;
    logic [GRID_COLS-1:0]    in_row;
    logic [GRID_COLS-1:0]    new_row;
    logic                    cell_bit;
    logic                    do_flip;
    logic                    res_alive;
    logic                    res_ignored;
    logic                    load_out;

    assign accept    = i_req.valid && i_req.ready;
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    assign in_range = (32'(r_col) < GRID_COLS) && (32'(r_row) < GRID_ROWS);
    assign col_idx  = COL_AW'(32'(r_col));
    assign row_idx  = ROW_AW'(32'(r_row));

    assign row_data = r_rvalid ? r_rdata : '0;
    assign in_row   = (r_rvalid && (r_cnt <= CNT_ROWS)) ? r_rdata : '0;
    assign cell_bit = row_data[col_idx];

    assign do_flip = (r_type == lgge_pkg::REQ_TOGGLE) && in_range && r_pause;
    assign res_alive = in_range && (cell_bit ^ do_flip);
    assign res_ignored = ((r_type == lgge_pkg::REQ_TICK) && r_pause)
                      || ((r_type == lgge_pkg::REQ_TOGGLE) && (!in_range || !r_pause))
                      || ((r_type == lgge_pkg::REQ_READ) && !in_range);
    assign load_out = (r_state == S_CELL) && slot_free;

    lgge_row_unit #(
        .GRID_COLS (GRID_COLS)
    ) u_row_unit (
        .i_prev (r_prev),
        .i_cur  (r_cur),
        .i_next (in_row),
        .o_row  (new_row)
    );

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = row_idx;
        wr_en   = 1'b0;
        wr_addr = row_idx;
        wr_data = row_data;
        case (r_state)
            S_LOOK: begin
                rd_en = 1'b1;
            end
            S_CELL: begin
                wr_en   = load_out && do_flip;
                wr_data = row_data ^ (GRID_COLS'(1) << col_idx);
            end
            S_GEN: begin
                rd_en   = (r_cnt < CNT_ROWS);
                rd_addr = ROW_AW'(r_cnt);
                wr_en   = (r_cnt >= CNT_LAG);
                wr_addr = ROW_AW'(r_cnt - CNT_LAG);
                wr_data = new_row;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pause     = r_pause;
        n_out_valid = r_out_valid && !o_rsp.ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (i_req.req_type == lgge_pkg::REQ_PAUSE) begin
                        n_pause = !r_pause;
                    end
                    if ((i_req.req_type == lgge_pkg::REQ_TICK) && !r_pause) begin
                        n_state = S_GEN;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_state = S_CELL;
            end
            S_CELL: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_GEN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_LOOK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pause     <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pause     <= n_pause;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_req.req_type;
            r_col  <= i_req.cell_col;
            r_row  <= i_req.cell_row;
        end
        if (load_out) begin
            r_alive   <= res_alive;
            r_paused  <= r_pause;
            r_ignored <= res_ignored;
        end
        if (r_state == S_GEN) begin
            if (r_cnt == '0) begin
                r_prev <= '0;
                r_cur  <= '0;
            end else begin
                r_prev <= r_cur;
                r_cur  <= in_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rvalid <= r_row_valid[rd_addr];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_alive = r_alive;
    assign o_rsp.paused     = r_paused;
    assign o_rsp.ignored    = r_ignored;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("Grid memory written while the sequencer is idle.");

    a_pause_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pause != $past(r_pause)))
        |-> $past(accept && (i_req.req_type == lgge_pkg::REQ_PAUSE)))
        else $error("Pause flag changed without a pause request.");

    a_rsp_from_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state == S_CELL))
        else $error("Response word loaded outside the cell stage.");

    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < GRID_ROWS))
        else $error("Row write beyond the last grid row.");
`endif

endmodule
